@@ rtl/lcd_rect_fill_command_stream_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle fill command stream
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_COMMAND_STREAM_ASSERT_SVH
`define LCD_RECT_FILL_COMMAND_STREAM_ASSERT_SVH

// same-cycle implication
`define LRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lrf_pkg.sv @@
// ----------------------------------------------------------------------------
// lrf_pkg
// Types and constants shared by the rectangle fill command stream modules.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H   = 2'd3;

    localparam logic [7:0] SCR_W_RESET = 8'd128;
    localparam logic [7:0] SCR_H_RESET = 8'd160;

    // panel command codes
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // header sequence positions
    localparam logic [3:0] STEP_CASET = 4'd0;
    localparam logic [3:0] STEP_XS    = 4'd2;
    localparam logic [3:0] STEP_XE    = 4'd4;
    localparam logic [3:0] STEP_RASET = 4'd5;
    localparam logic [3:0] STEP_YS    = 4'd7;
    localparam logic [3:0] STEP_YE    = 4'd9;
    localparam logic [3:0] STEP_RAMWR = 4'd10;
    localparam logic [3:0] STEP_PIXEL = 4'd11;

    // command queue
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;
    localparam int Q_CW    = Q_AW + 1;

    typedef struct packed {
        logic [7:0] col_off;
        logic [7:0] row_off;
        logic [7:0] scr_w;
        logic [7:0] scr_h;
    } t_cfg;

    typedef struct packed {
        logic        is_start;
        logic        drop;
        logic [7:0]  xs;
        logic [7:0]  xe;
        logic [7:0]  ys;
        logic [7:0]  ye;
        logic [15:0] color;
        logic [7:0]  w;
        logic [7:0]  h;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/lcd_rect_fill_command_stream.sv @@
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_stream
// Rectangle fill byte stream for a serial LCD panel: window setup commands
// followed by the fill colour, one byte per advance transaction during a fill.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | sink      | i_in_valid / o_in_stall   | action, rect x y w h, colour
//  out     | source    | o_out_valid / i_out_stall | byte, is_data, last
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | 2-bit index, 8-bit data
//
//  Sustained rate: one input transaction per cycle while o_in_stall is low, one
//  output byte per cycle while advances are queued and i_out_stall is low; an
//  advance's byte passes the queue write, then the back end's output register. The
//  4-entry command queue sets how far the front runs ahead while the output is
//  stalled, and o_in_stall rises when full. Reset is synchronous and clears all
//  control state; no sweep. Config writes are always ready; the user must issue
//  them only while the block is idle; the block itself does not enforce it.
module lcd_rect_fill_command_stream
    import lrf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [7:0]           i_rect_x,
    input  logic [7:0]           i_rect_y,
    input  logic [7:0]           i_rect_w,
    input  logic [7:0]           i_rect_h,
    input  logic [15:0]          i_fill_color,
    // output transactions
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_is_data,
    output logic                 o_last,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    w_front_cmd;
    t_cmd    w_head_cmd;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_off <= 8'd0;
            r_cfg.row_off <= 8'd0;
            r_cfg.scr_w   <= SCR_W_RESET;
            r_cfg.scr_h   <= SCR_H_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COL_OFF: r_cfg.col_off <= i_cfg_data;
                CFG_ROW_OFF: r_cfg.row_off <= i_cfg_data;
                CFG_SCR_W:   r_cfg.scr_w   <= i_cfg_data;
                CFG_SCR_H:   r_cfg.scr_h   <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front: classify and clip, straight into the queue
    lrf_front u_front (
        .i_cfg        (r_cfg),
        .i_action     (i_action),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .i_fill_color (i_fill_color),
        .o_cmd        (w_front_cmd)
    );

    assign o_in_stall = w_q_stat.full;
    assign w_push     = i_in_valid && !w_q_stat.full;

    lrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    // back: fill sequencer with registered output
    lrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

endmodule

@@ rtl/lrf_front.sv @@
// ----------------------------------------------------------------------------
// lrf_front
// Classifies input transactions; rejects and clips start rectangles and
// works out the offset window addresses.
// ----------------------------------------------------------------------------
module lrf_front
    import lrf_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic        i_action,
    input  logic [7:0]  i_rect_x,
    input  logic [7:0]  i_rect_y,
    input  logic [7:0]  i_rect_w,
    input  logic [7:0]  i_rect_h,
    input  logic [15:0] i_fill_color,
    output t_cmd        o_cmd
);

    logic [7:0] w_wc;
    logic [7:0] w_hc;

    always_comb begin
        // clip once the far edge passes the screen edge
        if (({1'b0, i_rect_x} + {1'b0, i_rect_w}) >= ({1'b0, i_cfg.scr_w} + 9'd1)) begin
            w_wc = i_cfg.scr_w - i_rect_x;
        end else begin
            w_wc = i_rect_w;
        end
        if (({1'b0, i_rect_y} + {1'b0, i_rect_h}) >= ({1'b0, i_cfg.scr_h} + 9'd1)) begin
            w_hc = i_cfg.scr_h - i_rect_y;
        end else begin
            w_hc = i_rect_h;
        end

        o_cmd.is_start = ~i_action;
        o_cmd.drop     = (i_rect_x >= i_cfg.scr_w) || (i_rect_y >= i_cfg.scr_h);
        o_cmd.xs       = i_rect_x + i_cfg.col_off;
        o_cmd.xe       = i_rect_x + w_wc + i_cfg.col_off - 8'd1;
        o_cmd.ys       = i_rect_y + i_cfg.row_off;
        o_cmd.ye       = i_rect_y + w_hc + i_cfg.row_off - 8'd1;
        o_cmd.color    = i_fill_color;
        o_cmd.w        = w_wc;
        o_cmd.h        = w_hc;
    end

endmodule

@@ rtl/lrf_queue.sv @@
// ----------------------------------------------------------------------------
// lrf_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_command_stream_assert.svh"

module lrf_queue
    import lrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd            = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == Q_CW'(Q_DEPTH));

    `LRF_ASSERT_NOW(a_no_overflow, i_push, r_count != Q_CW'(Q_DEPTH), "queue overflow")
    `LRF_ASSERT_NOW(a_no_underflow, i_pop, r_count != '0, "queue underflow")

endmodule

@@ rtl/lrf_back.sv @@
// ----------------------------------------------------------------------------
// lrf_back
// Executes queued commands: holds the fill state and produces one panel
// byte per advance during a fill into a registered output stage.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_command_stream_assert.svh"

module lrf_back
    import lrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_last
);

    logic        r_busy,  n_busy;
    logic [3:0]  r_step,  n_step;
    logic        r_low,   n_low;
    logic [7:0]  r_xs,    n_xs;
    logic [7:0]  r_xe,    n_xe;
    logic [7:0]  r_ys,    n_ys;
    logic [7:0]  r_ye,    n_ye;
    logic [15:0] r_color, n_color;
    logic [7:0]  r_cols,  n_cols;
    logic [7:0]  r_rows,  n_rows;
    logic [7:0]  r_cw,    n_cw;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_is_data;
    logic        r_last;

    logic        w_open;
    logic        w_pop;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_data;
    logic        w_fin;

    assign w_open = !r_out_valid || !i_out_stall;
    assign w_pop  = i_q_stat.not_empty && w_open;
    assign w_emit = w_pop && !i_cmd.is_start && r_busy;

    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_low   = r_low;
        n_xs    = r_xs;
        n_xe    = r_xe;
        n_ys    = r_ys;
        n_ye    = r_ye;
        n_color = r_color;
        n_cols  = r_cols;
        n_rows  = r_rows;
        n_cw    = r_cw;
        w_byte  = BYTE_ZERO;
        w_data  = 1'b1;
        w_fin   = 1'b0;

        if (w_pop && i_cmd.is_start) begin
            // a start aborts any fill, dropped or not
            n_busy = 1'b0;
            if (!i_cmd.drop) begin
                n_busy  = 1'b1;
                n_step  = STEP_CASET;
                n_low   = 1'b0;
                n_xs    = i_cmd.xs;
                n_xe    = i_cmd.xe;
                n_ys    = i_cmd.ys;
                n_ye    = i_cmd.ye;
                n_color = i_cmd.color;
                n_cols  = i_cmd.w;
                n_rows  = i_cmd.h;
                n_cw    = i_cmd.w;
            end
        end else if (w_emit) begin
            if (r_step != STEP_PIXEL) begin
                case (r_step)
                    STEP_CASET: begin w_byte = CMD_CASET; w_data = 1'b0; end
                    STEP_XS:    w_byte = r_xs;
                    STEP_XE:    w_byte = r_xe;
                    STEP_RASET: begin w_byte = CMD_RASET; w_data = 1'b0; end
                    STEP_YS:    w_byte = r_ys;
                    STEP_YE:    w_byte = r_ye;
                    STEP_RAMWR: begin w_byte = CMD_RAMWR; w_data = 1'b0; end
                    default:    w_byte = BYTE_ZERO;
                endcase
                n_step = r_step + 4'd1;
                // empty window: header only
                if ((r_step == STEP_RAMWR) && ((r_cols == 8'd0) || (r_rows == 8'd0))) begin
                    w_fin  = 1'b1;
                    n_busy = 1'b0;
                end
            end else if (!r_low) begin
                w_byte = r_color[15:8];
                n_low  = 1'b1;
            end else begin
                w_byte = r_color[7:0];
                n_low  = 1'b0;
                if (r_cols <= 8'd1) begin
                    if (r_rows <= 8'd1) begin
                        w_fin  = 1'b1;
                        n_busy = 1'b0;
                        n_cols = 8'd0;
                        n_rows = 8'd0;
                    end else begin
                        n_rows = r_rows - 8'd1;
                        n_cols = r_cw;
                    end
                end else begin
                    n_cols = r_cols - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_CASET;
            r_low       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_low  <= n_low;
            if (w_open) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs    <= n_xs;
        r_xe    <= n_xe;
        r_ys    <= n_ys;
        r_ye    <= n_ye;
        r_color <= n_color;
        r_cols  <= n_cols;
        r_rows  <= n_rows;
        r_cw    <= n_cw;
        if (w_open) begin
            r_out_byte <= w_byte;
            r_is_data  <= w_data;
            r_last     <= w_fin;
        end
    end

    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_is_data;
    assign o_last      = r_last;

    `LRF_ASSERT_NOW(a_step_range, 1'b1, r_step <= STEP_PIXEL, "header step out of range")
    `LRF_ASSERT_NOW(a_low_in_pixels, r_low, r_step == STEP_PIXEL, "low byte flag in header")
    `LRF_ASSERT_NEXT(a_last_idles, w_emit && w_fin, !r_busy, "busy after final byte")

endmodule
